/* design/pps_pkg.sv */
// Package for the PWM prescaler and period search: constants, codes and sequencer states.
`timescale 1ns / 1ps
package pps_pkg;

  // Largest period resolution the search starts from.
  localparam int unsigned MaxResolutionBitsDef = 16;

  // Width of the shared divider operands.
  localparam int unsigned DivW = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_CLOCK_HZ      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_RES_BITS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DEV_Q16   = 2'd2;

  localparam logic [31:0] CLOCK_HZ_RST   = 32'd170000000;
  localparam logic [4:0]  MIN_RES_RST    = 5'd8;
  localparam logic [15:0] MAX_DEV_RST    = 16'd655;

  // Largest prescaler the timer can take.
  localparam logic [16:0] PSC_MAX = 17'd65536;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FALLBACK = 2'd1,
    STATUS_NONE     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_CLK,
    ST_TRIAL,
    ST_DIV_ACT,
    ST_CHECK,
    ST_FINISH
  } state_e;

endpackage

/* design/pps_div.sv */
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module pps_div import pps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] quot_q;
  logic [DivW-1:0] den_q;

  logic [DivW:0]   rem_sh;
  logic [DivW:0]   rem_sub;
  logic            fits;

  // Bring down the next numerator bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_q, quot_q[DivW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= num_i;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= fits ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
      quot_q <= {quot_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* design/pwm_prescaler_period_search_top.sv */
// Top level of the PWM prescaler and period search with its sequencer and result register.
`timescale 1ns / 1ps
// A request first divides clock_hz by target_hz on the shared serial divider, then walks
// the resolutions from the top down: each is skipped, or when valid gets a division of
// clock_hz by the prescaled period and a tolerance check. A search ends in the finish state,
// which loads the result; a zero target goes straight there. Requests are taken only in idle,
// once the result is loaded, which a stalled result delays. Reset (rst_ni low, asynchronous)
// empties the result register, idles the sequencer and loads the configuration defaults.
module pwm_prescaler_period_search_top import pps_pkg::*; #(
  parameter int unsigned MAX_RESOLUTION_BITS = MaxResolutionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         target_hz_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         prescaler_minus_one_o,
  output logic [15:0]         period_minus_one_o,
  output logic [31:0]         actual_hz_o,
  output logic [4:0]          resolution_bits_o,
  output logic [1:0]          status_o
);

  // Width of the resolution counter, enough to hold MAX_RESOLUTION_BITS itself.
  localparam int unsigned BitsW = $clog2(MAX_RESOLUTION_BITS + 1);

  // Configuration registers. Software is to write them only while the block is idle, which
  // it does not enforce; the sequencer reads them directly, taking no copy per request.
  logic [31:0] clock_hz_q;
  logic [4:0]  min_res_q;
  logic [15:0] max_dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RST;
      min_res_q  <= MIN_RES_RST;
      max_dev_q  <= MAX_DEV_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLOCK_HZ:     clock_hz_q <= cfg_data_i[31:0];
        CFG_MIN_RES_BITS: min_res_q  <= cfg_data_i[4:0];
        CFG_MAX_DEV_Q16:  max_dev_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // A minimum resolution of zero behaves as one.
  logic [4:0] lo_bits;
  assign lo_bits = (min_res_q == 5'd0) ? 5'd1 : min_res_q;

  // Sequencer state and working registers.
  state_e           state_q, state_d;
  logic [31:0]      target_q;
  logic [47:0]      dev_lim_q;   // max_deviation_q16 * target, the tolerance bound
  logic [31:0]      divisor_q;   // clock_hz / target
  logic [BitsW-1:0] bits_q;      // resolution under trial
  logic [16:0]      psc_q;       // prescaler of the current trial
  logic [15:0]      best_psc_q;
  logic [15:0]      best_per_q;
  logic [31:0]      best_act_q;
  logic [BitsW-1:0] best_bits_q;
  status_e          best_st_q;

  // Result register.
  logic             out_valid_q;
  logic [15:0]      out_psc_q;
  logic [15:0]      out_per_q;
  logic [31:0]      out_act_q;
  logic [4:0]       out_bits_q;
  status_e          out_st_q;

  // Shared divider.
  logic        div_start;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [31:0] div_quot;

  pps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Trial arithmetic for the resolution under test.
  logic [31:0] psc_full;
  logic        psc_ok;
  logic        trials_over;
  logic [31:0] act_diff;
  logic        in_tol;
  logic        in_acc;
  logic        out_acc;
  logic        res_load;

  always_comb begin
    psc_full    = divisor_q >> bits_q;
    psc_ok      = (psc_full != 32'd0) && (psc_full <= 32'(PSC_MAX));
    trials_over = (5'(bits_q) < lo_bits);
    act_diff    = (div_quot > target_q) ? (div_quot - target_q) : (target_q - div_quot);
    in_tol      = ({act_diff, 16'd0} < dev_lim_q);
    in_acc      = in_valid_i && !in_stall_o;
    out_acc     = out_valid_q && !out_stall_i;
  end

  // Next state and control.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = clock_hz_q;
    div_den   = 32'(psc_full[16:0]) << bits_q;
    res_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        div_den = target_hz_i;
        if (in_valid_i) begin
          if (target_hz_i == 32'd0) begin
            state_d = ST_FINISH;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV_CLK;
          end
        end
      end
      ST_DIV_CLK: begin
        if (div_done) begin
          state_d = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        if (trials_over) begin
          state_d = ST_FINISH;
        end else if (psc_ok) begin
          div_start = 1'b1;
          state_d   = ST_DIV_ACT;
        end
      end
      ST_DIV_ACT: begin
        if (div_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = in_tol ? ST_FINISH : ST_TRIAL;
      end
      ST_FINISH: begin
        // Wait until the result register is free or is being emptied this cycle.
        if (!out_valid_q || !out_stall_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working datapath. The best-so-far fields start as the "nothing valid" answer and are
  // overwritten by every valid trial, so the last valid resolution survives as the fallback.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          target_q    <= target_hz_i;
          dev_lim_q   <= 48'(max_dev_q) * 48'(target_hz_i);
          bits_q      <= BitsW'(MAX_RESOLUTION_BITS);
          best_psc_q  <= '0;
          best_per_q  <= '0;
          best_act_q  <= '0;
          best_bits_q <= '0;
          best_st_q   <= STATUS_NONE;
        end
      end
      ST_DIV_CLK: begin
        if (div_done) begin
          divisor_q <= div_quot;
        end
      end
      ST_TRIAL: begin
        if (!trials_over) begin
          psc_q <= psc_full[16:0];
          if (!psc_ok) begin
            bits_q <= bits_q - 1'b1;
          end
        end
      end
      ST_CHECK: begin
        best_psc_q  <= 16'(psc_q - 17'd1);
        best_per_q  <= 16'((17'd1 << bits_q) - 17'd1);
        best_act_q  <= div_quot;
        best_bits_q <= bits_q;
        best_st_q   <= in_tol ? STATUS_OK : STATUS_FALLBACK;
        bits_q      <= bits_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_psc_q  <= best_psc_q;
      out_per_q  <= best_per_q;
      out_act_q  <= best_act_q;
      out_bits_q <= 5'(best_bits_q);
      out_st_q   <= best_st_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign prescaler_minus_one_o = out_psc_q;
  assign period_minus_one_o    = out_per_q;
  assign actual_hz_o           = out_act_q;
  assign resolution_bits_o     = out_bits_q;
  assign status_o              = out_st_q;

  // The divider only reports completion while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_CLK || state_q == ST_DIV_ACT))
    else $error("divider finished outside a division state");

  // A request with no valid setting reports all fields as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_NONE) |->
      (resolution_bits_o == 5'd0 && actual_hz_o == 32'd0 &&
       prescaler_minus_one_o == 16'd0 && period_minus_one_o == 16'd0))
    else $error("no-setting result carries non-zero fields");

  // A valid setting has a resolution in range and a matching period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_NONE) |->
      (resolution_bits_o != 5'd0 && resolution_bits_o <= 5'(MAX_RESOLUTION_BITS) &&
       period_minus_one_o == 16'((17'd1 << resolution_bits_o) - 17'd1)))
    else $error("resolution and period of the result disagree");

  // A request taken while a result waits must not disturb the waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_act_q) && $stable(out_bits_q))
    else $error("waiting result changed");

endmodule

/* verif/pwm_prescaler_period_search_top_tb.sv */
// Self-checking testbench for the PWM prescaler and period search block.
`timescale 1ns / 1ps
module pwm_prescaler_period_search_top_tb;
  import pps_pkg::*;

  // One result of the search, laid out as the result channel presents it.
  typedef struct packed {
    logic [15:0] psc_m1;
    logic [15:0] per_m1;
    logic [31:0] act_hz;
    logic [4:0]  res_bits;
    status_e     status;
  } pwm_setting_t;

  // The directed part is a table: each row either writes a register or sends a request.
  typedef enum logic {
    ROW_WRITE,
    ROW_SEND
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   reg_idx;
    logic [31:0]          value;
    logic                 typed;
    pwm_setting_t         want;
  } dir_row_t;

  // The answer for a zero target, an impossible minimum, or when every resolution is skipped.
  localparam pwm_setting_t NO_SETTING = '{16'd0, 16'd0, 32'd0, 5'd0, STATUS_NONE};

  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned ITEMS_PER_PHASE = 84;
  localparam int unsigned HOLD_PHASE      = 4;
  localparam int unsigned PAUSE_PHASE     = 6;
  localparam int unsigned HOLD_CYCLES     = 2500;
  // Worst case is sixteen valid trials plus the first division.
  localparam int unsigned DRAIN_TAIL      = 700;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;

  // Rows whose answer can be read straight off the behaviour carry it; the rest rely on the
  // predictor. The first rows run under the reset configuration, so they also check it.
  localparam dir_row_t DIRECTED_ROWS [0:25] = '{
    // Zero target is an error.
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd0,          1'b1, NO_SETTING},
    // A target above the clock leaves a zero divisor, so every prescaler is zero.
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'hFFFF_FFFF,  1'b1, NO_SETTING},
    // Lowest target: the full 16-bit period is accepted at once.
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd1,          1'b1,
      '{16'd2592, 16'd65535, 32'd1, 5'd16, STATUS_OK}},
    // Target equal to the clock: divisor of one, nothing valid.
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd170000000,  1'b1, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd20000,      1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd25000,      1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd663000,     1'b0, NO_SETTING},
    // No tolerance at all: valid settings can only end as a fallback.
    '{ROW_WRITE, CFG_MAX_DEV_Q16,  32'd0,          1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd1000,       1'b0, NO_SETTING},
    '{ROW_WRITE, CFG_MAX_DEV_Q16,  32'd65535,      1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd1000,       1'b0, NO_SETTING},
    // A minimum of zero behaves as a minimum of one; a divisor of two only fits one bit.
    '{ROW_WRITE, CFG_MIN_RES_BITS, 32'd0,          1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd80000000,   1'b0, NO_SETTING},
    // A minimum above sixteen means nothing is tried.
    '{ROW_WRITE, CFG_MIN_RES_BITS, 32'd17,         1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd1000,       1'b1, NO_SETTING},
    '{ROW_WRITE, CFG_MIN_RES_BITS, 32'd31,         1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd5,          1'b1, NO_SETTING},
    // A clock of zero makes every prescaler zero.
    '{ROW_WRITE, CFG_CLOCK_HZ,     32'd0,          1'b0, NO_SETTING},
    '{ROW_WRITE, CFG_MIN_RES_BITS, 32'd1,          1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd1,          1'b1, NO_SETTING},
    // Clock of 2^31 with no tolerance: 16 bits gives an exact but rejected answer, 15 bits
    // reaches the largest prescaler of 65536, and everything lower is skipped as too big.
    '{ROW_WRITE, CFG_CLOCK_HZ,     32'h8000_0000,  1'b0, NO_SETTING},
    '{ROW_WRITE, CFG_MAX_DEV_Q16,  32'd0,          1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd1,          1'b1,
      '{16'd65535, 16'd32767, 32'd1, 5'd15, STATUS_FALLBACK}},
    '{ROW_WRITE, CFG_CLOCK_HZ,     32'hFFFF_FFFF,  1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'd3,          1'b0, NO_SETTING},
    '{ROW_SEND,  CFG_CLOCK_HZ,     32'hFFFF_FFFF,  1'b1, NO_SETTING}
  };

  // Every input is given a known value from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [31:0]         target_hz_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [15:0]         prescaler_minus_one_o;
  logic [15:0]         period_minus_one_o;
  logic [31:0]         actual_hz_o;
  logic [4:0]          resolution_bits_o;
  logic [1:0]          status_o;

  // The testbench's own copy of the configuration registers, kept in step with every write.
  logic [31:0] cfg_clock_hz = CLOCK_HZ_RST;
  logic [4:0]  cfg_min_bits = MIN_RES_RST;
  logic [15:0] cfg_max_dev  = MAX_DEV_RST;

  // Expected search results, oldest first, one per accepted request.
  pwm_setting_t pending_settings[$];
  pwm_setting_t got_setting;
  pwm_setting_t want_setting;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;

  // Idling controls shared between the request source, the result sink and the sequence.
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_req     = 1'b0;

  pwm_prescaler_period_search_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .target_hz_i           (target_hz_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .prescaler_minus_one_o (prescaler_minus_one_o),
    .period_minus_one_o    (period_minus_one_o),
    .actual_hz_o           (actual_hz_o),
    .resolution_bits_o     (resolution_bits_o),
    .status_o              (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walks the resolutions from the top down and returns the first one inside the tolerance,
  // or else the last valid one as a fallback. Resolutions whose prescaler is zero or above
  // 65536 are skipped. Everything is done at 64 bits so nothing wraps.
  function automatic pwm_setting_t search_setting(input logic [31:0] target);
    pwm_setting_t    res;
    longint unsigned tgt;
    longint unsigned clk;
    longint unsigned dev;
    longint unsigned divisor;
    longint unsigned psc;
    longint unsigned act;
    longint unsigned diff;
    int              lo;
    int              b;
    res = NO_SETTING;
    tgt = target;
    clk = cfg_clock_hz;
    dev = cfg_max_dev;
    lo  = (cfg_min_bits == 5'd0) ? 1 : int'(cfg_min_bits);
    if (tgt != 0) begin
      divisor = clk / tgt;
      for (b = MaxResolutionBitsDef; b >= lo; b--) begin
        psc = divisor >> b;
        if (psc == 0 || psc > 65536) continue;
        act  = clk / (psc << b);
        diff = (act > tgt) ? act - tgt : tgt - act;
        res.psc_m1   = 16'(psc - 1);
        res.per_m1   = 16'((64'd1 << b) - 1);
        res.act_hz   = 32'(act);
        res.res_bits = 5'(b);
        res.status   = STATUS_FALLBACK;
        if ((diff << 16) < dev * tgt) begin
          res.status = STATUS_OK;
          break;
        end
      end
    end
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_setting(input pwm_setting_t got, input pwm_setting_t want);
    if (got.psc_m1 !== want.psc_m1) begin
      flag_mismatch("prescaler_minus_one", 32'(got.psc_m1), 32'(want.psc_m1));
    end
    if (got.per_m1 !== want.per_m1) begin
      flag_mismatch("period_minus_one", 32'(got.per_m1), 32'(want.per_m1));
    end
    if (got.act_hz !== want.act_hz) flag_mismatch("actual_hz", got.act_hz, want.act_hz);
    if (got.res_bits !== want.res_bits) begin
      flag_mismatch("resolution_bits", 32'(got.res_bits), 32'(want.res_bits));
    end
    if (got.status !== want.status) begin
      flag_mismatch("status", 32'(got.status), 32'(want.status));
    end
  endtask

  // The block must be idle for a register write, which the caller ensures.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_CLOCK_HZ:     cfg_clock_hz = data;
      CFG_MIN_RES_BITS: cfg_min_bits = data[4:0];
      CFG_MAX_DEV_Q16:  cfg_max_dev  = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one request and holds it until it is taken. Valid is left high afterwards, so the
  // next call or an idle burst must follow at the very next falling edge.
  task automatic send_target(input logic [31:0] target, input logic typed,
                             input pwm_setting_t want);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    target_hz_i <= target;
    do @(posedge clk_i); while (in_stall_o);
    pending_settings.push_back(typed ? want : search_setting(target));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stops offering requests and waits until every outstanding result has been taken. Each
  // request gives exactly one result, so an empty store means the block is idle.
  task automatic drain_requests();
    idle_sender(1);
    while (pending_settings.size() != 0) @(posedge clk_i);
  endtask

  // Result sink: random stall bursts, or one long hold-off when the sequence asks for it so
  // that the block fills up and has to stall its request side.
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_setting = '{prescaler_minus_one_o, period_minus_one_o, actual_hz_o,
                      resolution_bits_o, status_e'(status_o)};
      if (pending_settings.size() == 0) begin
        flag_mismatch("unexpected result, actual_hz", actual_hz_o, 32'd0);
      end else begin
        want_setting = pending_settings.pop_front();
        check_setting(got_setting, want_setting);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL pwm_prescaler_period_search_top");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] target;
    logic [31:0] dvs;
    int unsigned sh;
    int unsigned pick;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Register rows wait for the block to go idle before writing.
    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
        drain_requests();
        write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
      end else begin
        send_target(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
      end
    end

    // Random phases, each under a fresh configuration. The first few pin the extremes; the
    // last one runs with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_requests();
      if (p == 0) begin
        write_reg(CFG_CLOCK_HZ, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_RES_BITS, 32'd1);
        write_reg(CFG_MAX_DEV_Q16, 32'd65535);
      end else if (p == 1) begin
        write_reg(CFG_CLOCK_HZ, 32'd1);
        write_reg(CFG_MIN_RES_BITS, 32'd16);
        write_reg(CFG_MAX_DEV_Q16, 32'd0);
      end else begin
        write_reg(CFG_CLOCK_HZ, ($urandom_range(0, 3) == 0) ? CLOCK_HZ_RST : $urandom);
        if (p == 2) begin
          write_reg(CFG_MIN_RES_BITS, 32'd0);
        end else if (p == 3) begin
          write_reg(CFG_MIN_RES_BITS, $urandom_range(17, 31));
        end else if ($urandom_range(0, 9) == 0) begin
          write_reg(CFG_MIN_RES_BITS, $urandom_range(0, 31));
        end else begin
          write_reg(CFG_MIN_RES_BITS, $urandom_range(1, 16));
        end
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_MAX_DEV_Q16, 32'd0);
          1:       write_reg(CFG_MAX_DEV_Q16, 32'd65535);
          2:       write_reg(CFG_MAX_DEV_Q16, $urandom_range(0, 2000));
          default: write_reg(CFG_MAX_DEV_Q16, $urandom_range(0, 65535));
        endcase
      end

      src_idle_en  = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == HOLD_PHASE) hold_req = 1'b1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // Well-formed request: a target that leaves a divisor of a chosen size, so that
          // the search finds valid resolutions across the whole range.
          sh     = $urandom_range(1, 31);
          dvs    = (32'd1 << sh) | ($urandom & ((32'd1 << sh) - 32'd1));
          target = cfg_clock_hz / dvs;
          if (target == 32'd0) target = 32'd1;
        end else if (pick < 85) begin
          target = $urandom;
        end else if (pick < 95) begin
          target = $urandom_range(1, 255);
        end else begin
          case ($urandom_range(0, 2))
            0:       target = 32'd0;
            1:       target = 32'd1;
            default: target = 32'hFFFF_FFFF;
          endcase
        end
        send_target(target, 1'b0, NO_SETTING);
        if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
          drain_requests();
        end else if (src_idle_en && $urandom_range(0, 3) == 0) begin
          idle_sender($urandom_range(1, 6));
        end
      end
    end

    drain_requests();
    // Give a stray extra result time to show up before judging the run.
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0 && pending_settings.size() == 0) begin
      $display("PASS pwm_prescaler_period_search_top");
    end else begin
      $display("FAIL pwm_prescaler_period_search_top");
    end
    $finish;
  end

endmodule
